@@ design/rca_pkg.sv @@
// rca_pkg: shared types, constants and the gamma table of the RGB888 color ALU.
// Used by the channel interfaces and by every module of the block.
package rca_pkg;

  // Field widths of the words on both channels
  localparam int FUNC_W   = 3;
  localparam int COLOR_W  = 24;
  localparam int FACTOR_W = 16;
  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = 3;

  // Default number of fraction bits of the Q-format factor
  localparam int FACTOR_FRAC_BITS_DEF = 8;

  // Multiplier operand widths: 9-bit signed (channel or channel difference)
  // times 16-bit signed, giving a 25-bit signed product.
  localparam int MX_W   = CHAN_W + 1;
  localparam int PROD_W = MX_W + FACTOR_W;
  // Blend accumulator: product plus a << frac (at most 24 bits), one extra bit
  localparam int ACC_W  = PROD_W + 1;

  // Operation codes, as carried on the func field
  typedef enum logic [FUNC_W-1:0] {
    OP_ADD   = 3'd0,
    OP_MOD   = 3'd1,
    OP_SCALE = 3'd2,
    OP_MERGE = 3'd3,
    OP_GAMMA = 3'd4,
    OP_PASS  = 3'd7   // unused codes pass color_a through
  } op_e;

  // Stage 1 -> stage 2: decoded op and multiplier operands
  typedef struct packed {
    op_e                                 op;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]     a;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]     b;
    logic [NUM_CHAN-1:0][MX_W-1:0]       mx;
    logic [NUM_CHAN-1:0][FACTOR_W-1:0]   my;
    logic                                merge_ovf;
  } s1_t;

  // Stage 2 -> stage 3: products per channel
  typedef struct packed {
    op_e                                 op;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]     a;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]     b;
    logic [NUM_CHAN-1:0][PROD_W-1:0]     prod;
    logic                                merge_ovf;
  } s2_t;

  // Gamma table: largest y with y^11 <= c^5 * 255^6, built at elaboration
  typedef logic [CHAN_W-1:0] gamma_lut_t [256];

  function automatic gamma_lut_t gamma_lut_f();
    gamma_lut_t  lut;
    logic [95:0] rhs;
    logic [95:0] pw;
    logic [7:0]  y;
    logic [7:0]  t;
    for (int c = 0; c < 256; c++) begin
      rhs = 96'd1;
      for (int k = 0; k < 5; k++) rhs = rhs * 96'(c);
      for (int k = 0; k < 6; k++) rhs = rhs * 96'd255;
      y = 8'd0;
      // bitwise search, y^11 is monotonic
      for (int bt = 7; bt >= 0; bt--) begin
        t  = y | 8'(1 << bt);
        pw = 96'd1;
        for (int k = 0; k < 11; k++) pw = pw * 96'(t);
        if (pw <= rhs) y = t;
      end
      lut[c] = y;
    end
    return lut;
  endfunction

  localparam gamma_lut_t GAMMA_LUT = gamma_lut_f();

endpackage

@@ design/rca_if.sv @@
// rca_if: valid/ready channel interfaces for operand and result words.
// Depends on rca_pkg for field widths.
interface rca_in_if;
  logic                                valid;
  logic                                ready;
  logic [rca_pkg::FUNC_W-1:0]          func;
  logic [rca_pkg::COLOR_W-1:0]         color_a;
  logic [rca_pkg::COLOR_W-1:0]         color_b;
  logic signed [rca_pkg::FACTOR_W-1:0] factor;

  modport source (output valid, func, color_a, color_b, factor, input ready);
  modport sink   (input valid, func, color_a, color_b, factor, output ready);
endinterface

interface rca_out_if;
  logic                        valid;
  logic                        ready;
  logic [rca_pkg::COLOR_W-1:0] color_out;
  logic                        overflow;

  modport source (output valid, color_out, overflow, input ready);
  modport sink   (input valid, color_out, overflow, output ready);
endinterface

@@ design/rgb888_color_alu_core.sv @@
// rgb888_color_alu_core: top level of the RGB888 color ALU, three-stage pipeline.
// Depends on rca_pkg, rca_if, rca_prep, rca_mul and rca_fin.
//
//   channel | dir | handshake     | word
//   in_i    | in  | valid / ready | func, color_a, color_b, factor
//   out_o   | out | valid / ready | color_out, overflow
//
// One word per cycle sustained while out_o.ready stays high; a result is
// registered in turn by the operand select, multiply and finish/output
// registers before it is offered on out_o.
// Reset clears only the stage valid bits; no table needs filling.
// Each stage takes a word when it is empty or its successor takes one, so
// bubbles close up under a stalled output and nothing is dropped or repeated.
module rgb888_color_alu_core #(
  parameter int FACTOR_FRAC_BITS = rca_pkg::FACTOR_FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rca_in_if.sink    in_i,
  rca_out_if.source out_o
);
  import rca_pkg::*;

  s1_t  s1;
  s2_t  s2;
  logic s1_valid;
  logic s1_ready;
  logic s2_valid;
  logic s2_ready;

  rca_prep #(
    .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .s1_o    (s1),
    .valid_o (s1_valid),
    .ready_i (s1_ready)
  );

  rca_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s1_i    (s1),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .s2_o    (s2),
    .valid_o (s2_valid),
    .ready_i (s2_ready)
  );

  rca_fin #(
    .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
  ) u_fin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s2_i    (s2),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .out_o   (out_o)
  );

endmodule

@@ design/rca_prep.sv @@
// rca_prep: pipeline stage 1, decodes func and selects multiplier operands.
// Depends on rca_pkg and rca_in_if.
module rca_prep #(
  parameter int FACTOR_FRAC_BITS = rca_pkg::FACTOR_FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rca_in_if.sink       in_i,
  output rca_pkg::s1_t s1_o,
  output logic         valid_o,
  input  logic         ready_i
);
  import rca_pkg::*;

  // 1.0 in the factor's fixed-point format; 18 bits hold it up to 16 frac bits
  localparam logic signed [FACTOR_W+1:0] ONE = (FACTOR_W+2)'(1) <<< FACTOR_FRAC_BITS;

  logic valid_q;
  s1_t  s1_d;
  s1_t  s1_q;

  // Operand selection per channel
  always_comb begin
    logic [CHAN_W-1:0]             ca;
    logic [CHAN_W-1:0]             cb;
    logic signed [FACTOR_W+1:0]    f_ext;
    f_ext = (FACTOR_W+2)'(in_i.factor);
    case (in_i.func)
      OP_ADD:   s1_d.op = OP_ADD;
      OP_MOD:   s1_d.op = OP_MOD;
      OP_SCALE: s1_d.op = OP_SCALE;
      OP_MERGE: s1_d.op = OP_MERGE;
      OP_GAMMA: s1_d.op = OP_GAMMA;
      default:  s1_d.op = OP_PASS;
    endcase
    // merge ratio outside 0..1
    s1_d.merge_ovf = (f_ext < 0) || (f_ext > ONE);
    for (int i = 0; i < NUM_CHAN; i++) begin
      ca = in_i.color_a[i*CHAN_W +: CHAN_W];
      cb = in_i.color_b[i*CHAN_W +: CHAN_W];
      s1_d.a[i] = ca;
      s1_d.b[i] = cb;
      case (s1_d.op)
        OP_MOD: begin
          s1_d.mx[i] = {1'b0, ca};
          s1_d.my[i] = FACTOR_W'(cb);
        end
        OP_SCALE: begin
          s1_d.mx[i] = {1'b0, ca};
          s1_d.my[i] = in_i.factor;
        end
        OP_MERGE: begin
          // a*(1-r) + b*r = (a << frac) + (b-a)*r
          s1_d.mx[i] = {1'b0, cb} - {1'b0, ca};
          s1_d.my[i] = in_i.factor;
        end
        default: begin
          s1_d.mx[i] = '0;
          s1_d.my[i] = '0;
        end
      endcase
    end
  end

  assign in_i.ready = !valid_q || ready_i;

  // Stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q <= s1_d;
    end
  end

  assign s1_o    = s1_q;
  assign valid_o = valid_q;

endmodule

@@ design/rca_mul.sv @@
// rca_mul: pipeline stage 2, one 9x16 signed multiplier per channel.
// Depends on rca_pkg.
module rca_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  rca_pkg::s1_t s1_i,
  input  logic         valid_i,
  output logic         ready_o,
  output rca_pkg::s2_t s2_o,
  output logic         valid_o,
  input  logic         ready_i
);
  import rca_pkg::*;

  logic valid_q;
  s2_t  s2_d;
  s2_t  s2_q;

  // Products, both operands sign-extended to the full product width
  always_comb begin
    s2_d.op        = s1_i.op;
    s2_d.a         = s1_i.a;
    s2_d.b         = s1_i.b;
    s2_d.merge_ovf = s1_i.merge_ovf;
    for (int i = 0; i < NUM_CHAN; i++) begin
      s2_d.prod[i] = PROD_W'($signed(s1_i.mx[i])) * PROD_W'($signed(s1_i.my[i]));
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      s2_q <= s2_d;
    end
  end

  assign s2_o    = s2_q;
  assign valid_o = valid_q;

endmodule

@@ design/rca_fin.sv @@
// rca_fin: pipeline stage 3, finishes each channel (saturating add, clamp,
// divide by 255, gamma lookup) and holds the result word. Depends on rca_pkg and rca_out_if.
module rca_fin #(
  parameter int FACTOR_FRAC_BITS = rca_pkg::FACTOR_FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  rca_pkg::s2_t s2_i,
  input  logic         valid_i,
  output logic         ready_o,
  rca_out_if.source    out_o
);
  import rca_pkg::*;

  localparam int FB = FACTOR_FRAC_BITS;

  logic               valid_q;
  logic [COLOR_W-1:0] color_d;
  logic [COLOR_W-1:0] color_q;
  logic               ovf_d;
  logic               ovf_q;

  // Per-channel result
  always_comb begin
    logic [ACC_W-1:0]  prod_ext;
    logic [ACC_W-1:0]  a_sh;
    logic [ACC_W-1:0]  v;
    logic              neg;
    logic              hi_nz;
    logic              over;
    logic [CHAN_W-1:0] sat;
    logic [15:0]       mx;
    logic [15:0]       msum;
    logic [CHAN_W:0]   s;
    logic [CHAN_W-1:0] res;
    ovf_d = (s2_i.op == OP_MERGE) && s2_i.merge_ovf;
    for (int i = 0; i < NUM_CHAN; i++) begin
      // scale / merge accumulator and clamp
      prod_ext = {s2_i.prod[i][PROD_W-1], s2_i.prod[i]};
      a_sh     = ACC_W'(s2_i.a[i]) << FB;
      v        = (s2_i.op == OP_MERGE) ? prod_ext + a_sh : prod_ext;
      neg      = v[ACC_W-1];
      hi_nz    = |v[ACC_W-2:FB+CHAN_W];
      // above 255.0 exactly
      over     = hi_nz || ((&v[FB +: CHAN_W]) && (|v[FB-1:0]));
      sat      = neg ? '0 : (hi_nz ? '1 : v[FB +: CHAN_W]);
      // x / 255 for x < 2^16: (x + (x >> 8) + 1) >> 8
      mx       = s2_i.prod[i][15:0];
      msum     = mx + {8'd0, mx[15:8]} + 16'd1;
      // saturating add
      s        = {1'b0, s2_i.a[i]} + {1'b0, s2_i.b[i]};
      case (s2_i.op)
        OP_ADD: begin
          res = s[CHAN_W] ? '1 : s[CHAN_W-1:0];
          if (s[CHAN_W]) ovf_d = 1'b1;
        end
        OP_MOD:   res = msum[15:8];
        OP_SCALE: begin
          res = sat;
          if (neg || over) ovf_d = 1'b1;
        end
        OP_MERGE: res = sat;
        OP_GAMMA: res = GAMMA_LUT[s2_i.a[i]];
        default:  res = s2_i.a[i];
      endcase
      color_d[i*CHAN_W +: CHAN_W] = res;
    end
  end

  assign ready_o = !valid_q || out_o.ready;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      color_q <= color_d;
      ovf_q   <= ovf_d;
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.color_out = color_q;
  assign out_o.overflow  = ovf_q;

endmodule
